// ===== src/rcpa_pkg.sv =====
// ----------------------------------------------------------------------------
// rcpa_pkg
// Shared types and codes of the reference-counted page allocator: command and
// status codes and the packed request and response transactions.
// ----------------------------------------------------------------------------
`default_nettype none

package rcpa_pkg;

    // Fixed field widths
    localparam int ADDR_W       = 27;
    localparam int FIRST_PAGE_W = 15;
    localparam int REF_OUT_W    = 16;

    // Command codes
    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_FREE    = 2'd1;
    localparam logic [1:0] CMD_ADD_REF = 2'd2;
    localparam logic [1:0] CMD_READ    = 2'd3;

    // Status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NO_MEM   = 2'd1;
    localparam logic [1:0] STAT_BAD_ADDR = 2'd2;
    localparam logic [1:0] STAT_COUNT    = 2'd3;

    // Request transaction
    typedef struct packed {
        logic [1:0]        command;
        logic [ADDR_W-1:0] address;
    } rcpa_in_t;

    // Response transaction
    typedef struct packed {
        logic [1:0]           status;
        logic [ADDR_W-1:0]    page_address;
        logic [REF_OUT_W-1:0] ref_count;
        logic                 page_freed;
    } rcpa_out_t;

endpackage

`default_nettype wire

// ===== src/refcounted_page_allocator.sv =====
// ----------------------------------------------------------------------------
// refcounted_page_allocator
// Physical page allocator with a reference count per page held in a count
// RAM and a last-in-first-out free list held in a stack RAM.
// ----------------------------------------------------------------------------
//
//   Port group     Role       Handshake          Payload
//   s_*            request    s_valid/s_ready    rcpa_in_t  (command, address)
//   m_*            response   m_valid/m_ready    rcpa_out_t (status, page, count)
//   cfg_*          register   cfg_wr_en          first_usable_page
//
// Free and add-ref run as count RAM read, then modify and write back; read-ref
// reads the count RAM and responds. Allocate from the free list runs as stack
// RAM read, count RAM read, write back. The next request is taken once the
// previous one has written back; a held response stalls write-back until it
// is taken. After reset a clearing pass over all NUM_PAGES entries zeroes the
// count RAM with s_ready low; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
`default_nettype none

module refcounted_page_allocator #(
    parameter int NUM_PAGES  = 32768,
    parameter int PAGE_BYTES = 4096,   // power of two
    parameter int COUNT_BITS = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire rcpa_pkg::rcpa_in_t     s_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output rcpa_pkg::rcpa_out_t         m_data,
    input  wire logic                   cfg_wr_en,
    input  wire logic [14:0]            cfg_wr_data
);

    import rcpa_pkg::*;

    localparam int PAGE_W  = $clog2(NUM_PAGES);
    localparam int DEPTH_W = $clog2(NUM_PAGES + 1);
    localparam int OFF_W   = $clog2(PAGE_BYTES);

    localparam logic [PAGE_W-1:0]     LAST_PAGE = PAGE_W'(NUM_PAGES - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STACK,
        ST_EXEC
    } state_t;

    state_t                  state_reg,      state_next;
    logic [PAGE_W-1:0]       clr_idx_reg,    clr_idx_next;
    logic [1:0]              cmd_reg,        cmd_next;
    logic [PAGE_W-1:0]       page_reg,       page_next;
    logic                    bad_reg,        bad_next;
    logic                    oom_reg,        oom_next;
    logic                    from_stack_reg, from_stack_next;
    logic [DEPTH_W-1:0]      depth_reg,      depth_next;
    logic [DEPTH_W-1:0]      fresh_reg,      fresh_next;
    logic [FIRST_PAGE_W-1:0] first_reg,      first_next;
    logic                    m_valid_reg,    m_valid_next;
    rcpa_out_t               out_reg,        out_next;

    // RAM ports
    logic                    cnt_we;
    logic [PAGE_W-1:0]       cnt_waddr;
    logic [COUNT_BITS-1:0]   cnt_wdata;
    logic [PAGE_W-1:0]       cnt_raddr;
    logic [COUNT_BITS-1:0]   cnt_rdata;
    logic                    stk_we;
    logic [PAGE_W-1:0]       stk_waddr;
    logic [PAGE_W-1:0]       stk_wdata;
    logic [PAGE_W-1:0]       stk_raddr;
    logic [PAGE_W-1:0]       stk_rdata;

    // Request decode
    logic [31:0]             in_page32;
    logic                    in_ok;
    logic [PAGE_W-1:0]       in_page;
    logic [DEPTH_W-1:0]      fresh_dec;
    logic [PAGE_W-1:0]       fresh_page;
    logic                    fresh_avail;
    logic                    stack_room;

    // Execute stage helpers
    logic [COUNT_BITS-1:0]   cnt_inc;
    logic [COUNT_BITS-1:0]   cnt_dec;
    logic                    cnt_at_max;
    logic                    cnt_zero;
    logic [31:0]             paddr32;
    logic [31:0]             cnt_rd32;
    logic [31:0]             cnt_inc32;
    logic [31:0]             cnt_dec32;
    logic                    out_free;

    rcpa_ram #(
        .DEPTH (NUM_PAGES),
        .WIDTH (COUNT_BITS)
    ) u_count_ram (
        .aclk    (aclk),
        .wr_en   (cnt_we),
        .wr_addr (cnt_waddr),
        .wr_data (cnt_wdata),
        .rd_addr (cnt_raddr),
        .rd_data (cnt_rdata)
    );

    rcpa_ram #(
        .DEPTH (NUM_PAGES),
        .WIDTH (PAGE_W)
    ) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (stk_we),
        .wr_addr (stk_waddr),
        .wr_data (stk_wdata),
        .rd_addr (stk_raddr),
        .rd_data (stk_rdata)
    );

    // Decode the request address into a page and check it
    assign in_page32   = 32'(s_data.address >> OFF_W);
    assign in_page     = in_page32[PAGE_W-1:0];
    assign in_ok       = (s_data.address[OFF_W-1:0] == '0)
                       && (in_page32 < 32'(NUM_PAGES))
                       && (in_page32 >= 32'(first_reg));
    assign fresh_dec   = fresh_reg - DEPTH_W'(1);
    assign fresh_page  = fresh_dec[PAGE_W-1:0];
    assign fresh_avail = 32'(fresh_reg) > 32'(first_reg);
    assign stack_room  = 32'(depth_reg) < 32'(NUM_PAGES);

    // Top of the free list is always being read
    logic [DEPTH_W-1:0] depth_dec;
    assign depth_dec = depth_reg - DEPTH_W'(1);
    assign stk_raddr = depth_dec[PAGE_W-1:0];

    // Count arithmetic on the read-back value
    assign cnt_inc    = cnt_rdata + COUNT_BITS'(1);
    assign cnt_dec    = cnt_rdata - COUNT_BITS'(1);
    assign cnt_at_max = (cnt_rdata == COUNT_MAX);
    assign cnt_zero   = (cnt_rdata == '0);
    assign cnt_rd32   = 32'(cnt_rdata);
    assign cnt_inc32  = 32'(cnt_inc);
    assign cnt_dec32  = 32'(cnt_dec);
    assign paddr32    = 32'(page_reg) << OFF_W;
    assign out_free   = !m_valid_reg || m_ready;

    always_comb begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        cmd_next        = cmd_reg;
        page_next       = page_reg;
        bad_next        = bad_reg;
        oom_next        = oom_reg;
        from_stack_next = from_stack_reg;
        depth_next      = depth_reg;
        fresh_next      = fresh_reg;
        first_next      = cfg_wr_en ? cfg_wr_data : first_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        out_next        = out_reg;

        cnt_we    = 1'b0;
        cnt_waddr = page_reg;
        cnt_wdata = cnt_inc;
        cnt_raddr = page_reg;
        stk_we    = 1'b0;
        stk_waddr = depth_reg[PAGE_W-1:0];
        stk_wdata = page_reg;

        case (state_reg)
            // Zero the count RAM one entry a cycle
            ST_CLEAR: begin
                cnt_we       = 1'b1;
                cnt_waddr    = clr_idx_reg;
                cnt_wdata    = '0;
                clr_idx_next = clr_idx_reg + PAGE_W'(1);
                if (clr_idx_reg == LAST_PAGE) begin
                    state_next = ST_IDLE;
                end
            end

            // Take a request and launch the first RAM read
            ST_IDLE: begin
                cnt_raddr = in_page;
                if (s_valid) begin
                    cmd_next        = s_data.command;
                    bad_next        = !in_ok;
                    page_next       = in_page;
                    oom_next        = 1'b0;
                    from_stack_next = 1'b0;
                    state_next      = ST_EXEC;
                    if (s_data.command == CMD_ALLOC) begin
                        if (depth_reg != '0) begin
                            from_stack_next = 1'b1;
                            state_next      = ST_STACK;
                        end else begin
                            cnt_raddr = fresh_page;
                            page_next = fresh_page;
                            oom_next  = !fresh_avail;
                        end
                    end
                end
            end

            // Popped page arrives: read its count
            ST_STACK: begin
                cnt_raddr  = stk_rdata;
                page_next  = stk_rdata;
                state_next = ST_EXEC;
            end

            // Modify, write back and post the response
            ST_EXEC: begin
                cnt_raddr = page_reg;
                if (out_free) begin
                    state_next            = ST_IDLE;
                    m_valid_next          = 1'b1;
                    out_next.status       = STAT_OK;
                    out_next.page_address = '0;
                    out_next.ref_count    = '0;
                    out_next.page_freed   = 1'b0;
                    case (cmd_reg)
                        CMD_ALLOC: begin
                            if (oom_reg) begin
                                out_next.status = STAT_NO_MEM;
                            end else if (cnt_at_max) begin
                                out_next.status    = STAT_COUNT;
                                out_next.ref_count = cnt_rd32[REF_OUT_W-1:0];
                            end else begin
                                cnt_we                = 1'b1;
                                cnt_wdata             = cnt_inc;
                                out_next.ref_count    = cnt_inc32[REF_OUT_W-1:0];
                                out_next.page_address = paddr32[ADDR_W-1:0];
                                if (from_stack_reg) begin
                                    depth_next = depth_dec;
                                end else begin
                                    fresh_next = fresh_dec;
                                end
                            end
                        end
                        CMD_FREE: begin
                            if (bad_reg) begin
                                out_next.status = STAT_BAD_ADDR;
                            end else if (cnt_zero) begin
                                out_next.status = STAT_COUNT;
                            end else begin
                                cnt_we             = 1'b1;
                                cnt_wdata          = cnt_dec;
                                out_next.ref_count = cnt_dec32[REF_OUT_W-1:0];
                                // Push the page once its last reference drops and the free list has room
                                if (cnt_dec == '0 && stack_room) begin
                                    stk_we              = 1'b1;
                                    depth_next          = depth_reg + DEPTH_W'(1);
                                    out_next.page_freed = 1'b1;
                                end
                            end
                        end
                        CMD_ADD_REF: begin
                            if (bad_reg) begin
                                out_next.status = STAT_BAD_ADDR;
                            end else if (cnt_at_max) begin
                                out_next.status    = STAT_COUNT;
                                out_next.ref_count = cnt_rd32[REF_OUT_W-1:0];
                            end else begin
                                cnt_we             = 1'b1;
                                cnt_wdata          = cnt_inc;
                                out_next.ref_count = cnt_inc32[REF_OUT_W-1:0];
                            end
                        end
                        CMD_READ: begin
                            if (bad_reg) begin
                                out_next.status = STAT_BAD_ADDR;
                            end else begin
                                out_next.ref_count = cnt_rd32[REF_OUT_W-1:0];
                            end
                        end
                        default: begin
                            out_next.status = STAT_OK;
                        end
                    endcase
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and the response register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            depth_reg   <= '0;
            fresh_reg   <= DEPTH_W'(NUM_PAGES);
            first_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            depth_reg   <= depth_next;
            fresh_reg   <= fresh_next;
            first_reg   <= first_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg        <= cmd_next;
        page_reg       <= page_next;
        bad_reg        <= bad_next;
        oom_reg        <= oom_next;
        from_stack_reg <= from_stack_next;
        out_reg        <= out_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

// ===== src/rcpa_ram.sv =====
// ----------------------------------------------------------------------------
// rcpa_ram
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpa_ram #(
    parameter int DEPTH = 32768,
    parameter int WIDTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire
